>>> src/crccg_pkg.sv
`default_nettype none
package crccg_pkg;

	localparam int DEGREE_W       = 6;
	localparam int POLY_W         = 32;
	localparam int CFG_DATA_W     = 32;
	localparam int CFG_INDEX_W    = 1;
	localparam int MAX_DEGREE_DEF = 32;
	localparam int DEGREE_RESET   = 16;

	localparam logic [POLY_W-1:0] POLY_RESET = 32'h0000_1021;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_DEGREE   = 1'b0,
		REG_POLY_LOW = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic step;
		logic fb;
	} cell_ctrl_t;

endpackage
`default_nettype wire

>>> src/crccg_cell.sv
`default_nettype none
module crccg_cell
	import crccg_pkg::*;
(
	input  wire             clk,
	input  wire             arst_n,
	input  wire cell_ctrl_t ctrl,
	input  wire             active,
	input  wire             tap,
	input  wire             prev,
	output logic            rem
);

	logic rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 1'b0;
		end else if (ctrl.step) begin
			rem_q <= active & (prev ^ (ctrl.fb & tap));
		end
	end

	assign rem = rem_q;

endmodule
`default_nettype wire

>>> src/crc_codeword_generator_unit.sv
// A message bit is registered at its transfer and appears at the output in the next cycle.
// One message bit is taken per cycle while the output is not stalled.
// After the bit flagged last, the degree remainder bits are shifted out,
// during which input is stalled.
// Reset clears the remainder and the output valid flag, but not the output bit,
// and sets degree to 16 (or MAX_DEGREE if smaller) and the polynomial to 0x1021.
`default_nettype none
module crc_codeword_generator_unit
	import crccg_pkg::*;
#(
	parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_wr_en,
	input  wire [CFG_INDEX_W-1:0] cfg_index,
	input  wire [CFG_DATA_W-1:0]  cfg_data,
	input  wire                   in_valid,
	output logic                  in_stall,
	input  wire                   message_bit,
	input  wire                   last,
	output logic                  out_valid,
	input  wire                   out_stall,
	output logic                  code_bit,
	output logic                  code_last
);

	localparam int DW = $clog2(MAX_DEGREE + 1);
	localparam int DEG_RST = (DEGREE_RESET > MAX_DEGREE) ? MAX_DEGREE : DEGREE_RESET;

	logic [DW-1:0]         degree_q;
	logic [POLY_W-1:0]     poly_q;
	logic [DEGREE_W-1:0]   wr_degree;
	logic [DW-1:0]         wr_eff;
	logic [MAX_DEGREE-1:0] rem_bits;
	logic [MAX_DEGREE-1:0] top_sel;
	logic                  top_bit;
	logic                  flush_q;
	logic [DW-1:0]         cnt_q;
	logic                  out_valid_q;
	logic                  code_bit_q;
	logic                  code_last_q;
	logic                  out_free;
	logic                  in_xfer;
	logic                  flush_step;
	cell_ctrl_t            ctrl;

	assign wr_degree = cfg_data[DEGREE_W-1:0];

	always_comb begin
		priority if (wr_degree == '0) begin
			wr_eff = DW'(1);
		end else if (wr_degree > DEGREE_W'(MAX_DEGREE)) begin
			wr_eff = DW'(MAX_DEGREE);
		end else begin
			wr_eff = DW'(wr_degree);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= DW'(DEG_RST);
			poly_q   <= POLY_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DEGREE:   degree_q <= wr_eff;
				REG_POLY_LOW: poly_q   <= cfg_data[POLY_W-1:0];
				default:      degree_q <= degree_q;
			endcase
		end
	end

	assign out_free   = !out_valid_q || !out_stall;
	assign in_stall   = flush_q || !out_free;
	assign in_xfer    = in_valid && !in_stall;
	assign flush_step = flush_q && out_free;

	for (genvar i = 0; i < MAX_DEGREE; i++) begin : g_sel
		assign top_sel[i] = (degree_q == DW'(i + 1));
	end
	assign top_bit = |(rem_bits & top_sel);

	assign ctrl.step = in_xfer || flush_step;
	assign ctrl.fb   = in_xfer && (top_bit ^ message_bit);

	for (genvar i = 0; i < MAX_DEGREE; i++) begin : g_cell
		logic prev_bit;
		logic tap_bit;
		if (i == 0) begin : g_first
			assign prev_bit = 1'b0;
		end else begin : g_next
			assign prev_bit = rem_bits[i-1];
		end
		if (i < POLY_W) begin : g_tap
			assign tap_bit = poly_q[i];
		end else begin : g_notap
			assign tap_bit = 1'b0;
		end
		crccg_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.active (DW'(i) < degree_q),
			.tap    (tap_bit),
			.prev   (prev_bit),
			.rem    (rem_bits[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			flush_q     <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (out_free) begin
				out_valid_q <= in_xfer || flush_q;
			end
			if (in_xfer && last) begin
				flush_q <= 1'b1;
				cnt_q   <= degree_q;
			end else if (flush_step) begin
				flush_q <= (cnt_q != DW'(1));
				cnt_q   <= cnt_q - DW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			code_bit_q  <= message_bit;
			code_last_q <= 1'b0;
		end else if (flush_step) begin
			code_bit_q  <= top_bit;
			code_last_q <= (cnt_q == DW'(1));
		end
	end

	assign out_valid = out_valid_q;
	assign code_bit  = code_bit_q;
	assign code_last = code_last_q;

	a_last_starts_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && last) |=> flush_q)
		else $error("Flush did not start after the last message bit.");

	a_flush_count: assert property (@(posedge clk) disable iff (!arst_n)
		flush_q |-> (cnt_q != '0))
		else $error("Flush is active with no remainder bits left.");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(flush_q) |-> (rem_bits == '0))
		else $error("Remainder is not clear after the flush.");

	a_code_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && code_last_q) |-> !flush_q)
		else $error("Final codeword bit is shown while the flush continues.");

endmodule
`default_nettype wire
